// ===== sv/lpc_pkg.sv =====
// Package for the lidar polar-to-cartesian block: constants, payload structs
// and the CORDIC arctangent table. No dependencies.
`default_nettype none

package lpc_pkg;

   // points per packet is 2**POINTS_LOG2 (32 points)
   localparam int POINTS_LOG2     = 5;
   localparam int CORDIC_STAGES   = 16;
   localparam int NUM_ITER        = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

   localparam int WRAP_HUNDREDTHS = 36000;
   localparam int FULL_CIRCLE     = 1152000;   // 360 deg in 1/3200 deg
   localparam int PHASE_DIV       = 1125;      // FULL_CIRCLE / 2**10
   // floor(2**42 / 1125): phase = ang * 2**22 / 1125 via reciprocal
   localparam logic [31:0] PHASE_RECIP = 32'd3909374676;
   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

   // a negative span wraps the 64-bit interpolation product; its offset
   // 2**(64 - POINTS_LOG2) mod 360 deg, plus one turn to keep the sum positive
   localparam logic [63:0] NEG_SHIFT = 64'd1 << (64 - POINTS_LOG2);
   localparam int NEG_WRAP = int'(NEG_SHIFT % 64'(FULL_CIRCLE)) + FULL_CIRCLE;

   // raw angle width before the modulo, and compare/subtract steps needed
   localparam int ANG_W     = (((26 - POINTS_LOG2) > 21) ? (26 - POINTS_LOG2) : 21) + 1;
   localparam int MOD_STEPS = ANG_W - 20;
   localparam int ANGR_W    = 21;

   typedef struct packed {
      logic [31:0] phase;
      logic [15:0] distance;
   } phase_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic [1:0]         quad;
      logic [15:0]        distance;
   } trig_type;

   // atan(2**-i) as a fraction of a full turn, 2**32 per turn
   function automatic logic signed [32:0] atan_turn(input int i);
      logic [29:0] v;
      case (i)
         0:       v = 30'h20000000;
         1:       v = 30'h12E4051E;
         2:       v = 30'h09FB385B;
         3:       v = 30'h051111D4;
         4:       v = 30'h028B0D43;
         5:       v = 30'h0145D7E1;
         6:       v = 30'h00A2F61E;
         7:       v = 30'h00517C55;
         8:       v = 30'h0028BE53;
         9:       v = 30'h00145F2F;
         10:      v = 30'h000A2F98;
         11:      v = 30'h000517CC;
         12:      v = 30'h00028BE6;
         13:      v = 30'h000145F3;
         14:      v = 30'h0000A2FA;
         15:      v = 30'h0000517D;
         16:      v = 30'h000028BE;
         17:      v = 30'h0000145F;
         18:      v = 30'h00000A30;
         19:      v = 30'h00000518;
         20:      v = 30'h0000028C;
         21:      v = 30'h00000146;
         22:      v = 30'h000000A3;
         default: v = 30'h00000051;
      endcase
      return $signed({3'b000, v});
   endfunction

endpackage

`default_nettype wire

// ===== sv/lpc_angle.sv =====
// Angle front end: unwrap, interpolate, modulo 360 deg, scale to a 32-bit
// binary angle. Five register stages. Uses lpc_pkg.
`default_nettype none

module lpc_angle (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [15:0]      pkt_start,
   input  wire logic [15:0]      pkt_end,
   input  wire logic [4:0]       point_index,
   input  wire logic [15:0]      distance,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output lpc_pkg::phase_type    out_data
);
   import lpc_pkg::*;

   localparam int NS = 5;

   logic            vld_ff [0:NS-1];
   logic            rdy    [0:NS];

   // stage 1
   logic [15:0]     st1_start_ff;
   logic [20:0]     st1_prod_ff, st1_prod_in;
   logic            st1_neg_ff, st1_neg_in;
   logic [15:0]     st1_dist_ff;
   logic [16:0]     end_ext;
   logic            span_neg;
   logic [15:0]     span;
   // stage 2
   logic [ANGR_W-1:0] st2_ang_ff, st2_ang_in;
   logic [15:0]     st2_dist_ff;
   logic [ANG_W-1:0] ang_raw;
   // stage 3
   logic [52:0]     st3_mult_ff, st3_mult_in;
   logic [ANGR_W-1:0] st3_ang_ff;
   logic [15:0]     st3_dist_ff;
   // stage 4
   logic [31:0]     st4_est_ff;
   logic [42:0]     st4_estp_ff, st4_estp_in;
   logic [ANGR_W-1:0] st4_ang_ff;
   logic [15:0]     st4_dist_ff;
   // stage 5
   logic [31:0]     st5_phase_ff, st5_phase_in;
   logic [15:0]     st5_dist_ff;
   logic [42:0]     rem;

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) vld_ff[k] <= 1'b0;
      end else begin
         if (rdy[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (rdy[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // stage 1: unwrap end angle, |span| * index; start above end + 360 deg
   // leaves a negative span
   always_comb begin
      end_ext = (pkt_end < pkt_start) ? ({1'b0, pkt_end} + 17'(WRAP_HUNDREDTHS))
                                      : {1'b0, pkt_end};
      span_neg    = (end_ext < {1'b0, pkt_start});
      span        = span_neg ? 16'({1'b0, pkt_start} - end_ext)
                             : 16'(end_ext - {1'b0, pkt_start});
      st1_prod_in = {5'b0, span} * {16'b0, point_index};
      st1_neg_in  = span_neg && (point_index != 5'd0);
   end

   // stage 2: angle in 1/3200 deg, then reduce by conditional subtracts
   always_comb begin
      ang_raw = ANG_W'({st1_start_ff, 5'b0});
      if (st1_neg_ff) begin
         ang_raw = ang_raw + ANG_W'(NEG_WRAP)
                 - ANG_W'(({st1_prod_ff, 5'b0} + 26'((1 << POINTS_LOG2) - 1)) >> POINTS_LOG2);
      end else begin
         ang_raw = ang_raw + ANG_W'({st1_prod_ff, 5'b0} >> POINTS_LOG2);
      end
      for (int k = MOD_STEPS - 1; k >= 0; k--) begin
         if (ang_raw >= ANG_W'(FULL_CIRCLE << k)) begin
            ang_raw = ang_raw - ANG_W'(FULL_CIRCLE << k);
         end
      end
      st2_ang_in = ANGR_W'(ang_raw);
   end

   // stage 3: reciprocal multiply
   assign st3_mult_in = {32'b0, st2_ang_ff} * {21'b0, PHASE_RECIP};

   // stage 4: estimate is low by at most two; form est * 1125 for the check
   assign st4_estp_in = {11'b0, st3_mult_ff[51:20]} * 43'(PHASE_DIV);

   // stage 5: correct the estimate from the remainder
   always_comb begin
      rem = {st4_ang_ff, 22'b0} - st4_estp_ff;
      if (rem >= 43'(2 * PHASE_DIV)) begin
         st5_phase_in = st4_est_ff + 32'd2;
      end else if (rem >= 43'(PHASE_DIV)) begin
         st5_phase_in = st4_est_ff + 32'd1;
      end else begin
         st5_phase_in = st4_est_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         st1_start_ff <= pkt_start;
         st1_prod_ff  <= st1_prod_in;
         st1_neg_ff   <= st1_neg_in;
         st1_dist_ff  <= distance;
      end
      if (rdy[1]) begin
         st2_ang_ff  <= st2_ang_in;
         st2_dist_ff <= st1_dist_ff;
      end
      if (rdy[2]) begin
         st3_mult_ff <= st3_mult_in;
         st3_ang_ff  <= st2_ang_ff;
         st3_dist_ff <= st2_dist_ff;
      end
      if (rdy[3]) begin
         st4_est_ff  <= st3_mult_ff[51:20];
         st4_estp_ff <= st4_estp_in;
         st4_ang_ff  <= st3_ang_ff;
         st4_dist_ff <= st3_dist_ff;
      end
      if (rdy[4]) begin
         st5_phase_ff <= st5_phase_in;
         st5_dist_ff  <= st4_dist_ff;
      end
   end

   assign out_data.phase    = st5_phase_ff;
   assign out_data.distance = st5_dist_ff;

endmodule

`default_nettype wire

// ===== sv/lpc_cordic.sv =====
// Quadrant split and pipelined rotation CORDIC, one stage per iteration.
// Uses lpc_pkg.
`default_nettype none

module lpc_cordic (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire lpc_pkg::phase_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output lpc_pkg::trig_type     out_data
);
   import lpc_pkg::*;

   localparam int NS = NUM_ITER + 1;

   logic                vld_ff  [0:NS-1];
   logic                rdy     [0:NS];
   logic signed [33:0]  x_ff    [0:NS-1];
   logic signed [33:0]  y_ff    [0:NS-1];
   logic signed [32:0]  r_ff    [0:NS-1];
   logic [1:0]          quad_ff [0:NS-1];
   logic [15:0]         dist_ff [0:NS-1];
   logic signed [33:0]  x_in    [1:NS-1];
   logic signed [33:0]  y_in    [1:NS-1];
   logic signed [32:0]  r_in    [1:NS-1];
   logic [1:0]          quad_in;
   logic signed [31:0]  resid_in;
   logic [31:0]         phase_rnd;

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) vld_ff[k] <= 1'b0;
      end else begin
         if (rdy[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (rdy[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // nearest quadrant; residual lands in [-45, 45) deg, so a 32-bit wrap is exact
   always_comb begin
      phase_rnd = in_data.phase + 32'h2000_0000;
      quad_in   = phase_rnd[31:30];
      resid_in  = $signed(in_data.phase - {quad_in, 30'b0});
   end

   // iteration k-1 sits between registers k-1 and k; zero residual rotates positive
   always_comb begin
      for (int k = 1; k < NS; k++) begin
         if (r_ff[k-1] >= 0) begin
            x_in[k] = x_ff[k-1] - (y_ff[k-1] >>> (k - 1));
            y_in[k] = y_ff[k-1] + (x_ff[k-1] >>> (k - 1));
            r_in[k] = r_ff[k-1] - atan_turn(k - 1);
         end else begin
            x_in[k] = x_ff[k-1] + (y_ff[k-1] >>> (k - 1));
            y_in[k] = y_ff[k-1] - (x_ff[k-1] >>> (k - 1));
            r_in[k] = r_ff[k-1] + atan_turn(k - 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         x_ff[0]    <= GAIN_Q30;
         y_ff[0]    <= '0;
         r_ff[0]    <= 33'(resid_in);
         quad_ff[0] <= quad_in;
         dist_ff[0] <= in_data.distance;
      end
      for (int k = 1; k < NS; k++) begin
         if (rdy[k]) begin
            x_ff[k]    <= x_in[k];
            y_ff[k]    <= y_in[k];
            r_ff[k]    <= r_in[k];
            quad_ff[k] <= quad_ff[k-1];
            dist_ff[k] <= dist_ff[k-1];
         end
      end
   end

   assign out_data.x        = x_ff[NS-1];
   assign out_data.y        = y_ff[NS-1];
   assign out_data.quad     = quad_ff[NS-1];
   assign out_data.distance = dist_ff[NS-1];

endmodule

`default_nettype wire

// ===== sv/lpc_scale.sv =====
// Back end: round and clamp cos/sin to Q1.16, map to quadrant, scale by the
// distance and round to whole units. Three stages, last one is the output.
`default_nettype none

module lpc_scale (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire lpc_pkg::trig_type in_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic signed [16:0]    rsp_x_coord,
   output logic signed [16:0]    rsp_y_coord,
   output logic                  rsp_point_valid
);
   import lpc_pkg::*;

   localparam int NS = 3;

   localparam logic [1:0] QUAD_0   = 2'd0;
   localparam logic [1:0] QUAD_90  = 2'd1;
   localparam logic [1:0] QUAD_180 = 2'd2;
   localparam logic [1:0] QUAD_270 = 2'd3;

   logic               vld_ff [0:NS-1];
   logic               rdy    [0:NS];

   logic signed [33:0] cos_w, sin_w;
   logic signed [17:0] cos_c, sin_c;
   logic signed [17:0] cs_ff, cs_in, ss_ff, ss_in;
   logic [15:0]        st1_dist_ff, st2_dist_ff;
   logic signed [34:0] dist_ext, cs_ext, ss_ext;
   logic signed [34:0] px_ff, px_in, py_ff, py_in;
   logic signed [34:0] rx, ry;
   logic signed [16:0] x_ff, x_in, y_ff, y_in;
   logic               pv_ff, pv_in;

   always_comb begin
      rdy[NS] = !rsp_stall;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign in_ready  = rdy[0];
   assign rsp_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) vld_ff[k] <= 1'b0;
      end else begin
         if (rdy[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (rdy[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // stage 1: Q3.30 -> Q1.16 with round, clamp to +-1.0, quadrant swap
   always_comb begin
      cos_w = (in_data.x + 34'sd8192) >>> 14;
      sin_w = (in_data.y + 34'sd8192) >>> 14;
      if (cos_w > 34'sd65536)       cos_c = 18'sd65536;
      else if (cos_w < -34'sd65536) cos_c = -18'sd65536;
      else                          cos_c = 18'(cos_w);
      if (sin_w > 34'sd65536)       sin_c = 18'sd65536;
      else if (sin_w < -34'sd65536) sin_c = -18'sd65536;
      else                          sin_c = 18'(sin_w);
      unique case (in_data.quad)
         QUAD_0: begin
            cs_in = cos_c;
            ss_in = sin_c;
         end
         QUAD_90: begin
            cs_in = -sin_c;
            ss_in = cos_c;
         end
         QUAD_180: begin
            cs_in = -cos_c;
            ss_in = -sin_c;
         end
         QUAD_270: begin
            cs_in = sin_c;
            ss_in = -cos_c;
         end
         default: begin
            cs_in = cos_c;
            ss_in = sin_c;
         end
      endcase
   end

   // stage 2: distance times trig
   always_comb begin
      dist_ext = $signed({19'b0, st1_dist_ff});
      cs_ext   = 35'(cs_ff);
      ss_ext   = 35'(ss_ff);
      px_in    = dist_ext * cs_ext;
      py_in    = dist_ext * ss_ext;
   end

   // stage 3: round to whole units; no return gives zeros
   always_comb begin
      rx    = px_ff + 35'sd32768;
      ry    = py_ff + 35'sd32768;
      pv_in = (st2_dist_ff != 16'd0);
      x_in  = pv_in ? $signed(rx[32:16]) : 17'sd0;
      y_in  = pv_in ? $signed(ry[32:16]) : 17'sd0;
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         cs_ff       <= cs_in;
         ss_ff       <= ss_in;
         st1_dist_ff <= in_data.distance;
      end
      if (rdy[1]) begin
         px_ff       <= px_in;
         py_ff       <= py_in;
         st2_dist_ff <= st1_dist_ff;
      end
      if (rdy[2]) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         pv_ff <= pv_in;
      end
   end

   assign rsp_x_coord     = x_ff;
   assign rsp_y_coord     = y_ff;
   assign rsp_point_valid = pv_ff;

endmodule

`default_nettype wire

// ===== sv/lidar_point_polar_to_cartesian.sv =====
// Top level of the lidar polar-to-cartesian converter.
// Chains lpc_angle, lpc_cordic and lpc_scale; uses lpc_pkg.
//
//   channel | dir | payload                                          | flow
//   req_    | in  | packet start/end angle, point_index, distance    | valid/stall
//   rsp_    | out | x_coord, y_coord, point_valid                    | valid/stall
//
// One point per cycle sustained while rsp_stall is low. Pipeline stages:
// angle scaling, one register per CORDIC iteration, and the distance
// multiply with output rounding.
// Synchronous reset clears the stage valid bits only.
// rsp_stall holds the output register; earlier stages keep filling empty
// slots, so req_stall rises only once every stage holds a point.
`default_nettype none

module lidar_point_polar_to_cartesian (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [15:0]   req_start_angle,
   input  wire logic [15:0]   req_end_angle,
   input  wire logic [4:0]    req_point_index,
   input  wire logic [15:0]   req_distance,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic signed [16:0] rsp_x_coord,
   output logic signed [16:0] rsp_y_coord,
   output logic               rsp_point_valid
);
   import lpc_pkg::*;

   logic      ang_in_ready;
   logic      ang_valid, ang_ready;
   phase_type ang_data;
   logic      cor_valid, cor_ready;
   trig_type  cor_data;

   assign req_stall = !ang_in_ready;

   lpc_angle u_angle (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (ang_in_ready),
      .pkt_start   (req_start_angle),
      .pkt_end     (req_end_angle),
      .point_index (req_point_index),
      .distance    (req_distance),
      .out_valid   (ang_valid),
      .out_ready   (ang_ready),
      .out_data    (ang_data)
   );

   lpc_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ang_valid),
      .in_ready  (ang_ready),
      .in_data   (ang_data),
      .out_valid (cor_valid),
      .out_ready (cor_ready),
      .out_data  (cor_data)
   );

   lpc_scale u_scale (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (cor_valid),
      .in_ready        (cor_ready),
      .in_data         (cor_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_x_coord     (rsp_x_coord),
      .rsp_y_coord     (rsp_y_coord),
      .rsp_point_valid (rsp_point_valid)
   );

endmodule

`default_nettype wire

// ===== sv/lpc_checker.sv =====
// Port-level checks for lidar_point_polar_to_cartesian, attached by bind.
// No package dependency.
`default_nettype none

module lpc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [16:0] rsp_x_coord,
   input wire logic [16:0] rsp_y_coord,
   input wire logic        rsp_point_valid
);

   // a stalled result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_x_coord)
         && $stable(rsp_y_coord) && $stable(rsp_point_valid))
      else $error("stalled result changed");

   // no return must read as the origin
   a_no_return: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_point_valid |-> rsp_x_coord == 17'd0 && rsp_y_coord == 17'd0)
      else $error("no-return point with nonzero coordinates");

   // |distance * trig| never reaches 65536 after rounding
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_x_coord != 17'h10000 && rsp_y_coord != 17'h10000)
      else $error("coordinate out of range");

   // reset empties the pipe; right after it no result is valid and the input is not stalled
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // input side only stalls while a result waits under back pressure
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without back pressure");

endmodule

bind lidar_point_polar_to_cartesian lpc_checker u_lpc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_x_coord     (rsp_x_coord),
   .rsp_y_coord     (rsp_y_coord),
   .rsp_point_valid (rsp_point_valid)
);

`default_nettype wire
